// ===== rtl/core/spf_sieve_factorizer_unit_assert.svh =====
// Assertion macros for the smallest-prime-factor factorizer.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SPF_SIEVE_FACTORIZER_UNIT_ASSERT_SVH
`define SPF_SIEVE_FACTORIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/spf_pkg.sv =====
// Shared types and constants for the smallest-prime-factor factorizer.
// No dependencies.
`timescale 1ns / 1ps

package spf_pkg;

  localparam int unsigned NUM_W  = 16;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned PRIME_W = 9;

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_SV_RDP  = 8'b0000_0010,
    ST_SV_CHKP = 8'b0000_0100,
    ST_SV_MARK = 8'b0000_1000,
    ST_IDLE    = 8'b0001_0000,
    ST_FT_RD   = 8'b0010_0000,
    ST_FT_CHK  = 8'b0100_0000,
    ST_FT_DIV  = 8'b1000_0000
  } state_t;

endpackage

// ===== rtl/core/spf_sieve_factorizer_unit.sv =====
// Smallest-prime-factor sieve and factorizer, top level.
// Depends on spf_pkg and spf_sieve_factorizer_unit_assert.svh.
`timescale 1ns / 1ps
//
// Usage
//   Input stream (in_*): one 16-bit number per item in in_tdata[15:0].
//   Output stream (out_*): one item per prime factor, nondecreasing, with
//   multiplicity; out_tdata[15:0] is the factor, out_tlast marks the final
//   factor of a number and out_tuser flags an input of zero or above MAX_N.
//   An input of one, or an invalid input, gives a single item with factor 0.
// Reset
//   After rst_n the block clears the factor table, entries 0 to
//   min(MAX_N,65535), then runs the sieve, one table entry per cycle for
//   every multiple from p*p up of each prime p with p*p <= min(MAX_N,65535).
//   in_tready stays low until the table is complete.
// Factor steps
//   Each factor needs a table read, a check and, unless it is the last, a
//   16-step bit-serial divider that divides it out. A prime or special input
//   needs only the read and the check; the next number is taken only in idle.
// Stall
//   A result waits in the output register; the block holds the next factor
//   in its check state until out_tready frees that register.

`include "spf_sieve_factorizer_unit_assert.svh"

module spf_sieve_factorizer_unit #(
  parameter int unsigned MAX_N = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] number
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] factor
  output logic        out_tlast,  // is_last
  output logic        out_tuser   // [0] error
);

  localparam int unsigned LIM = (MAX_N > 65535) ? 65535 : MAX_N;
  localparam logic [15:0] LIM_V   = 16'(LIM);
  localparam logic [23:0] MAX_N_V = 24'(MAX_N);

  localparam int unsigned NW = spf_pkg::NUM_W;
  localparam int unsigned AW = spf_pkg::ADDR_W;
  localparam int unsigned PW = spf_pkg::PRIME_W;

  // table: 0 marks an unmarked entry (a prime), else its smallest prime factor
  logic [NW-1:0] mem [0:(1 << AW)-1];
  logic [NW-1:0] rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [NW-1:0] mem_wdata;

  spf_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [16:0]   m_r, m_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          err_r, err_nxt;
  logic [NW-1:0] f_r, f_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [NW-1:0] out_factor_r, out_factor_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_err_r, out_err_nxt;

  logic [17:0]   pp;
  logic          out_free;
  logic          in_acc;
  logic [NW-1:0] f_cur;
  logic [NW:0]   rem_sh, rem_diff;

  assign pp       = 18'(p_r) * 18'(p_r);
  assign in_tready = (state_r == spf_pkg::ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign f_cur    = (rdata_r == '0) ? n_r : rdata_r;
  assign rem_sh   = {rem_r, quo_r[NW-1]};
  assign rem_diff = rem_sh - {1'b0, f_r};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_factor_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    p_nxt          = p_r;
    m_nxt          = m_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    n_nxt          = n_r;
    err_nxt        = err_r;
    f_nxt          = f_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_factor_nxt = out_factor_r;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;
    mem_we         = 1'b0;
    mem_waddr      = pend_addr_r;
    mem_wdata      = NW'(p_r);
    mem_re         = 1'b0;
    mem_raddr      = n_r;

    // finish the read-modify-write of the previous marking read
    if (pend_r && rdata_r == '0) begin
      mem_we = 1'b1;
    end

    case (state_r)
      spf_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LIM_V) begin
          p_nxt     = PW'(2);
          state_nxt = spf_pkg::ST_SV_RDP;
        end
      end
      spf_pkg::ST_SV_RDP: begin
        if (pp > {2'b00, LIM_V}) begin
          state_nxt = spf_pkg::ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(p_r);
          state_nxt = spf_pkg::ST_SV_CHKP;
        end
      end
      spf_pkg::ST_SV_CHKP: begin
        if (rdata_r == '0) begin
          m_nxt     = pp[16:0];
          state_nxt = spf_pkg::ST_SV_MARK;
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = spf_pkg::ST_SV_RDP;
        end
      end
      spf_pkg::ST_SV_MARK: begin
        if (m_r <= {1'b0, LIM_V}) begin
          mem_re        = 1'b1;
          mem_raddr     = m_r[AW-1:0];
          m_nxt         = m_r + 17'(p_r);
          pend_nxt      = 1'b1;
          pend_addr_nxt = m_r[AW-1:0];
        end else if (!pend_r) begin
          p_nxt     = p_r + 1'b1;
          state_nxt = spf_pkg::ST_SV_RDP;
        end
      end
      spf_pkg::ST_IDLE: begin
        if (in_acc) begin
          n_nxt     = in_tdata;
          err_nxt   = (in_tdata == '0) || ({8'h00, in_tdata} > MAX_N_V);
          state_nxt = spf_pkg::ST_FT_RD;
        end
      end
      spf_pkg::ST_FT_RD: begin
        // skip the table for out-of-range numbers
        mem_re    = !err_r;
        mem_raddr = n_r;
        state_nxt = spf_pkg::ST_FT_CHK;
      end
      spf_pkg::ST_FT_CHK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = err_r;
          if (err_r || n_r == NW'(1)) begin
            out_factor_nxt = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = spf_pkg::ST_IDLE;
          end else begin
            out_factor_nxt = f_cur;
            out_last_nxt   = (rdata_r == '0);
            if (rdata_r == '0) begin
              state_nxt = spf_pkg::ST_IDLE;
            end else begin
              f_nxt     = f_cur;
              quo_nxt   = n_r;
              rem_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = spf_pkg::ST_FT_DIV;
            end
          end
        end
      end
      spf_pkg::ST_FT_DIV: begin
        // one restoring step per cycle, MSB first
        if (!rem_diff[NW]) begin
          rem_nxt = rem_diff[NW-1:0];
          quo_nxt = {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[NW-1:0];
          quo_nxt = {quo_r[NW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'hF) begin
          n_nxt     = quo_nxt;
          state_nxt = spf_pkg::ST_FT_RD;
        end
      end
      default: begin
        state_nxt = spf_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spf_pkg::ST_CLEAR;
      clr_r       <= '0;
      p_r         <= PW'(2);
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      p_r         <= p_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r          <= m_nxt;
    pend_addr_r  <= pend_addr_nxt;
    n_r          <= n_nxt;
    err_r        <= err_nxt;
    f_r          <= f_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    out_factor_r <= out_factor_nxt;
    out_last_r   <= out_last_nxt;
    out_err_r    <= out_err_nxt;
  end

  `SPF_ASSERT_IMP(a_rmw_no_overlap, (mem_we && mem_re && state_r == spf_pkg::ST_SV_MARK),
    (mem_waddr != mem_raddr), "sieve read and write hit the same entry")
  `SPF_ASSERT_NXT(a_accept_reads, in_acc, (state_r == spf_pkg::ST_FT_RD),
    "accepted item did not start a table read")
  `SPF_ASSERT_IMP(a_div_factor, (state_r == spf_pkg::ST_FT_DIV), (f_r >= NW'(2)),
    "divider running with a factor below two")
  `SPF_ASSERT_NXT(a_div_quot, (state_r == spf_pkg::ST_FT_DIV && cnt_r == 4'hF),
    (n_r >= NW'(2)), "quotient of a composite fell below two")

endmodule

// ===== sim/spf_sieve_factorizer_unit_tb.sv =====
// Self-checking bench for spf_sieve_factorizer_unit: directed numbers, then random ones.
// Predicts factor items from its own sieve table, bar hand-typed rows; depends on spf_pkg and the RTL.
`timescale 1ns / 1ps

module spf_sieve_factorizer_unit_tb;

  localparam int unsigned NUM_W          = spf_pkg::NUM_W;
  localparam int unsigned MAX_N          = 65535;
  localparam int unsigned TABLE_TOP      = (MAX_N > 65535) ? 65535 : MAX_N;
  localparam int unsigned RANDOM_ITEMS   = 200;
  localparam int unsigned CALM_ITEMS     = 40;
  localparam int unsigned NUM_DIRECTED   = 21;
  localparam int unsigned DRAIN_CYCLES   = 300;
  // Must exceed the clear pass plus sieve, during which no item moves.
  localparam int unsigned WATCHDOG_LIMIT = 700000;

  typedef struct packed {
    logic [NUM_W-1:0] factor;
    logic             is_last;
    logic             err;
  } factor_item_t;

  // Rows marked known carry a single result typed in by hand.
  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic             known;
    logic [NUM_W-1:0] factor;
    logic             err;
  } directed_row_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [NUM_W-1:0] in_tdata   = '0;   // [15:0] number
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [NUM_W-1:0] out_tdata;         // [15:0] factor
  logic             out_tlast;         // is_last
  logic             out_tuser;         // [0] error

  logic [NUM_W-1:0] least_factor [0:65535];
  factor_item_t     pending_factors [$];

  bit          calm_tail     = 1'b0;
  int unsigned stall_left    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatches    = 0;
  int unsigned factors_seen  = 0;
  int unsigned numbers_sent  = 0;
  int unsigned invalid_sent  = 0;

  int unsigned small_primes [8] = '{2, 3, 5, 7, 11, 13, 17, 251};

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{16'd0,     1'b1, 16'd0,     1'b1},
    '{16'd1,     1'b1, 16'd0,     1'b0},
    '{16'd2,     1'b1, 16'd2,     1'b0},
    '{16'd3,     1'b1, 16'd3,     1'b0},
    '{16'd65521, 1'b1, 16'd65521, 1'b0},
    '{16'd4,     1'b0, 16'd0,     1'b0},
    '{16'd6,     1'b0, 16'd0,     1'b0},
    '{16'd8,     1'b0, 16'd0,     1'b0},
    '{16'd65535, 1'b0, 16'd0,     1'b0},
    '{16'd65534, 1'b0, 16'd0,     1'b0},
    '{16'd32768, 1'b0, 16'd0,     1'b0},
    '{16'd49152, 1'b0, 16'd0,     1'b0},
    '{16'd59049, 1'b0, 16'd0,     1'b0},
    '{16'd65025, 1'b0, 16'd0,     1'b0},
    '{16'd63001, 1'b0, 16'd0,     1'b0},
    '{16'd64507, 1'b0, 16'd0,     1'b0},
    '{16'd46189, 1'b0, 16'd0,     1'b0},
    '{16'd30030, 1'b0, 16'd0,     1'b0},
    '{16'd21845, 1'b0, 16'd0,     1'b0},
    '{16'd43690, 1'b0, 16'd0,     1'b0},
    '{16'd65519, 1'b0, 16'd0,     1'b0}
  };

  spf_sieve_factorizer_unit #(
    .MAX_N(MAX_N)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  function automatic void build_least_factor_table();
    int unsigned p, m;
    for (p = 0; p < 65536; p++) begin
      least_factor[p] = (p >= 2 && p <= TABLE_TOP) ? p[15:0] : '0;
    end
    for (p = 2; p * p <= TABLE_TOP; p++) begin
      if (least_factor[p] == p[15:0]) begin
        for (m = p * p; m <= TABLE_TOP; m += p) begin
          if (least_factor[m] == m[15:0]) least_factor[m] = p[15:0];
        end
      end
    end
  endfunction

  function automatic void push_factor(int unsigned factor, bit is_last, bit err);
    factor_item_t item;
    item.factor  = factor[NUM_W-1:0];
    item.is_last = is_last;
    item.err     = err;
    pending_factors.insert(pending_factors.size(), item);
  endfunction

  // Expected factor items for one number, smallest factor first.
  function automatic void predict_factors(logic [NUM_W-1:0] number);
    int unsigned n, f, count;
    n = number;
    count = 0;
    if (n == 0 || n > MAX_N) begin
      push_factor(0, 1'b1, 1'b1);
      return;
    end
    if (n == 1) begin
      push_factor(0, 1'b1, 1'b0);
      return;
    end
    while (n != 1 && count < 16) begin
      f = least_factor[n[15:0]];
      if (f < 2) f = n;
      n = n / f;
      push_factor(f, n == 1, 1'b0);
      count++;
    end
  endfunction

  function automatic logic [NUM_W-1:0] random_number();
    int unsigned kind, v, p;
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      v = $urandom_range(0, 1);
    end else if (kind <= 5) begin
      v = $urandom_range(0, 65535);
    end else if (kind <= 11) begin
      // Smooth numbers give long runs of repeated factors.
      v = 1;
      repeat ($urandom_range(1, 15)) begin
        p = small_primes[$urandom_range(0, 7)];
        if (v * p <= 65535) v = v * p;
      end
      if (v == 1) v = 2;
    end else if (kind <= 13) begin
      v = ($urandom_range(1, 255) << $urandom_range(0, 8)) & 16'hFFFF;
    end else begin
      v = $urandom_range(32768, 65535);
    end
    return v[NUM_W-1:0];
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic send_number(logic [NUM_W-1:0] number);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= number;
    do @(posedge clk); while (!in_tready);
    numbers_sent++;
    if (number == 0 || number > MAX_N) invalid_sent++;
  endtask

  // Hold the sender off until every outstanding factor item has come back.
  task automatic drain_pending();
    in_tvalid <= 1'b0;
    while (pending_factors.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_monitor
    factor_item_t want;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      factors_seen++;
      if (pending_factors.size() == 0) begin
        report_mismatch("unexpected factor item", out_tdata, 0);
      end else begin
        want = pending_factors.pop_front();
        if (out_tdata !== want.factor) report_mismatch("factor", out_tdata, want.factor);
        if (out_tlast !== want.is_last) report_mismatch("tlast", out_tlast, want.is_last);
        if (out_tuser !== want.err) report_mismatch("error flag", out_tuser, want.err);
      end
    end
  end

  initial begin
    logic [NUM_W-1:0] number;
    build_least_factor_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_number(directed_rows[i].number);
      if (directed_rows[i].known)
        push_factor(directed_rows[i].factor, 1'b1, directed_rows[i].err);
      else
        predict_factors(directed_rows[i].number);
    end
    drain_pending();

    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) drain_pending();
      if (k == RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
      number = random_number();
      send_number(number);
      predict_factors(number);
    end
    drain_pending();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d numbers (%0d directed, %0d invalid), %0d factor items compared",
             numbers_sent, NUM_DIRECTED, invalid_sent, factors_seen);
    $display("random stalls on both sides, three full drains, calm tail of %0d numbers",
             CALM_ITEMS);
    if (mismatches == 0 && pending_factors.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/spf_pkg.sv
rtl/core/spf_sieve_factorizer_unit.sv
sim/spf_sieve_factorizer_unit_tb.sv
